// File: src/clq_pkg.sv
// Shared constants, codes and types of the CRLF line framer.
`default_nettype none
package clq_pkg;

    // Sizes
    localparam int STORE_BYTES = 2048;
    localparam int QUEUE_DEPTH = 64;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = $clog2(STORE_BYTES);
    localparam int RADDR_W  = $clog2(STORE_BYTES + 1);
    localparam int CNT_W    = $clog2(STORE_BYTES + 1);
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = BYTE_W + RADDR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ADDR_W + BYTE_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE    = 2'd0,
        REQ_OVERRUN = 2'd1,
        REQ_POP     = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_DISCARD = 3'd2,
        ST_FULL    = 3'd3,
        ST_POPPED  = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_READ    = 3'd6,
        ST_QFULL   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TERM,
        S_COPY,
        S_DONE
    } t_state;

    // Port requests toward the line store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    // Port requests toward the start address queue
    typedef struct packed {
        logic              we;
        logic [QPTR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
        logic              re;
        logic [QPTR_W-1:0] raddr;
    } t_queue_req;

    // One result item
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] start_addr;
        logic [BYTE_W-1:0] read_data;
        logic              sentence_ready;
    } t_result;

endpackage
`default_nettype wire

// File: src/crlf_line_framer_with_queue_top.sv
// Top level: stream ports, line store and queue memories, output register.
//
//  channel   dir  tuser           tdata (lowest bits first)
//  s_axis    in   req_type[1:0]   byte_value[7:0], read_addr[19:8]
//  m_axis    out  status[2:0]     start_addr[10:0], read_data[18:11], sentence_ready[19]
//
// Each item passes through S_IDLE and S_DONE; a line end (CR then LF) also passes S_TERM,
// writing LF and terminator through the single write port of the line store.
// A byte that wraps the write position adds a move of n = STORE_BYTES - line_start
// bytes, one per cycle through the line store, in S_COPY.
// Reset is synchronous; the memories are not cleared.
// The output register lets the next item enter while a result waits; a result
// stalled on m_axis holds the sequencer only when its own result is ready.
`default_nettype none
module crlf_line_framer_with_queue_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [clq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // byte_value, read_addr
    input  wire logic [clq_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [clq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // start_addr, read_data,
                                                                    // sentence_ready
    output logic      [clq_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);
    import clq_pkg::*;

    t_store_req        store_req;
    t_queue_req        queue_req;
    logic [BYTE_W-1:0] store_rdata;
    logic [ADDR_W-1:0] queue_rdata;
    logic              res_valid, res_ready;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    clq_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req         (t_req'(s_axis_tuser)),
        .i_byte        (s_axis_tdata[BYTE_W-1:0]),
        .i_read_addr   (s_axis_tdata[BYTE_W +: RADDR_W]),
        .o_store       (store_req),
        .i_store_rdata (store_rdata),
        .o_queue       (queue_req),
        .i_queue_rdata (queue_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // Line store
    clq_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_req.we),
        .i_waddr (store_req.waddr),
        .i_wdata (store_req.wdata),
        .i_re    (store_req.re),
        .i_raddr (store_req.raddr),
        .o_rdata (store_rdata)
    );

    // Sentence start address queue
    clq_ram #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (queue_req.we),
        .i_waddr (queue_req.waddr),
        .i_wdata (queue_req.wdata),
        .i_re    (queue_req.re),
        .i_raddr (queue_req.raddr),
        .o_rdata (queue_rdata)
    );

    // Output register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            r_out.sentence_ready, r_out.read_data, r_out.start_addr};

endmodule
`default_nettype wire

// File: src/clq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none
module clq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/clq_seq.sv
// Sequencer: framing state, line store and queue accesses, wrap move.
`default_nettype none
module clq_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire clq_pkg::t_req                 i_req,
    input  wire logic [clq_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic [clq_pkg::RADDR_W-1:0]   i_read_addr,
    // memories
    output clq_pkg::t_store_req                o_store,
    input  wire logic [clq_pkg::BYTE_W-1:0]    i_store_rdata,
    output clq_pkg::t_queue_req                o_queue,
    input  wire logic [clq_pkg::ADDR_W-1:0]    i_queue_rdata,
    // result
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output clq_pkg::t_result                   o_res
);
    import clq_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_write_pos, n_write_pos;
    logic [ADDR_W-1:0] r_line_start, n_line_start;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic              r_resync, n_resync;
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QPTR_W-1:0] r_tail, n_tail;
    // move and result bookkeeping
    logic [ADDR_W-1:0] r_src, n_src;
    logic [ADDR_W-1:0] r_dst, n_dst;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_wpend, n_wpend;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_start, n_start;
    logic              r_from_q, n_from_q;
    logic              r_rd_ok, n_rd_ok;

    logic              accept;
    logic [ADDR_W-1:0] wp_next, wp_prev;
    logic [QPTR_W-1:0] tail_next, head_next;
    logic              is_full, is_crlf, is_wrap;
    logic [CNT_W-1:0]  move_len;

    // Pointer arithmetic and byte classification
    always_comb begin
        wp_next   = (r_write_pos == ADDR_W'(STORE_BYTES - 1)) ? '0 : r_write_pos + ADDR_W'(1);
        wp_prev   = (r_write_pos == '0) ? ADDR_W'(STORE_BYTES - 1) : r_write_pos - ADDR_W'(1);
        tail_next = (r_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QPTR_W'(1);
        head_next = (r_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + QPTR_W'(1);
        move_len  = CNT_W'(STORE_BYTES) - CNT_W'(r_line_start);
        is_full   = (wp_next == r_line_start);
        is_crlf   = !is_full && (i_byte == CHAR_LF) && (r_prev == CHAR_CR);
        is_wrap   = !is_full && !is_crlf && (r_write_pos == ADDR_W'(STORE_BYTES - 1));
    end

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req == REQ_BYTE && is_crlf) begin
                        n_state = S_TERM;
                    end else if (i_req == REQ_BYTE && is_wrap && r_line_start != '0) begin
                        n_state = S_COPY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TERM: n_state = S_DONE;
            S_COPY: begin
                if (r_cnt == '0 && !r_wpend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates and memory requests
    always_comb begin
        n_write_pos  = r_write_pos;
        n_line_start = r_line_start;
        n_prev       = r_prev;
        n_resync     = r_resync;
        n_head       = r_head;
        n_tail       = r_tail;
        n_src        = r_src;
        n_dst        = r_dst;
        n_cnt        = r_cnt;
        n_wpend      = r_wpend;
        n_status     = r_status;
        n_start      = r_start;
        n_from_q     = r_from_q;
        n_rd_ok      = r_rd_ok;
        o_store      = '0;
        o_queue      = '0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_start  = '0;
                    n_from_q = 1'b0;
                    n_rd_ok  = 1'b0;
                    case (i_req)
                        REQ_BYTE: begin
                            n_prev = i_byte;
                            if (is_full) begin
                                n_resync = 1'b1;
                                n_status = ST_FULL;
                            end else if (is_crlf) begin
                                // LF over the CR slot now, terminator next cycle
                                o_store.we    = 1'b1;
                                o_store.waddr = wp_prev;
                                o_store.wdata = CHAR_LF;
                                n_dst         = r_write_pos;
                                if (r_resync) begin
                                    n_resync = 1'b0;
                                    n_status = ST_DISCARD;
                                end else if (tail_next == r_head) begin
                                    n_status = ST_QFULL;
                                end else begin
                                    o_queue.we    = 1'b1;
                                    o_queue.waddr = r_tail;
                                    o_queue.wdata = r_line_start;
                                    n_tail        = tail_next;
                                    n_start       = r_line_start;
                                    n_status      = ST_QUEUED;
                                end
                                n_write_pos  = wp_next;
                                n_line_start = wp_next;
                            end else begin
                                o_store.we    = 1'b1;
                                o_store.waddr = r_write_pos;
                                o_store.wdata = i_byte;
                                n_status      = ST_STORED;
                                n_write_pos   = wp_next;
                                if (is_wrap) begin
                                    // move the partial line down to address 0
                                    n_write_pos  = (r_line_start == '0) ? '0 : ADDR_W'(move_len);
                                    n_line_start = '0;
                                    n_src        = r_line_start;
                                    n_dst        = '0;
                                    n_cnt        = move_len;
                                    n_wpend      = 1'b0;
                                end
                            end
                        end
                        REQ_OVERRUN: begin
                            n_resync = 1'b1;
                            n_status = ST_DISCARD;
                        end
                        REQ_POP: begin
                            if (r_head != r_tail) begin
                                o_queue.re    = 1'b1;
                                o_queue.raddr = r_head;
                                n_head        = head_next;
                                n_from_q      = 1'b1;
                                n_status      = ST_POPPED;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                        REQ_READ: begin
                            o_store.re    = 1'b1;
                            o_store.raddr = i_read_addr[ADDR_W-1:0];
                            n_rd_ok       = (i_read_addr < RADDR_W'(STORE_BYTES));
                            n_status      = ST_READ;
                        end
                        default: n_status = ST_READ;
                    endcase
                end
            end
            S_TERM: begin
                o_store.we    = 1'b1;
                o_store.waddr = r_dst;
                o_store.wdata = '0;
            end
            S_COPY: begin
                // read one byte ahead, write the byte read last cycle
                o_store.re    = (r_cnt != '0);
                o_store.raddr = r_src;
                o_store.we    = r_wpend;
                o_store.waddr = r_dst;
                o_store.wdata = i_store_rdata;
                n_wpend       = (r_cnt != '0);
                if (r_cnt != '0) begin
                    n_src = r_src + ADDR_W'(1);
                    n_cnt = r_cnt - CNT_W'(1);
                end
                if (r_wpend) begin
                    n_dst = r_dst + ADDR_W'(1);
                end
            end
            S_DONE: begin
                o_res_valid          = 1'b1;
                o_res.status         = r_status;
                o_res.start_addr     = r_from_q ? i_queue_rdata : r_start;
                o_res.read_data      = r_rd_ok ? i_store_rdata : '0;
                o_res.sentence_ready = (r_head != r_tail);
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_pos  <= '0;
            r_line_start <= '0;
            r_prev       <= '0;
            r_resync     <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_cnt        <= '0;
            r_wpend      <= 1'b0;
            r_from_q     <= 1'b0;
            r_rd_ok      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_pos  <= n_write_pos;
            r_line_start <= n_line_start;
            r_prev       <= n_prev;
            r_resync     <= n_resync;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_cnt        <= n_cnt;
            r_wpend      <= n_wpend;
            r_from_q     <= n_from_q;
            r_rd_ok      <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_status <= n_status;
        r_start  <= n_start;
    end

`ifndef SYNTHESIS
    // the move never reads the entry it writes in the same cycle
    a_copy_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_store.we && o_store.re) |-> (o_store.waddr != o_store.raddr))
        else $error("line store read and write collide");

    // a push never makes the queue look empty
    a_push_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_queue.we) |=> (r_head != r_tail))
        else $error("start queue overflow");

    // during the move the line already starts at 0 and the write position is set
    a_copy_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_line_start == '0 && r_write_pos != '0))
        else $error("wrap move with bad pointers");

    // a delivered result frees the sequencer
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> (r_state == S_IDLE))
        else $error("sequencer stuck after result");
`endif

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Testbench for the CRLF line framer: directed table, random traffic, wrap and full phases.
`default_nettype none
module tb_top;
    import clq_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 26;
    localparam int SCRIPT_LEN   = 23;

    // Clock, reset and stream signals; those the testbench drives are known from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // byte_value, read_addr
    logic [REQ_W-1:0]       s_axis_tuser  = '0;  // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // start_addr, read_data, sentence_ready
    logic [STATUS_W-1:0]    m_axis_tuser;        // status

    crlf_line_framer_with_queue_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Framer state as the testbench sees it
    logic [BYTE_W-1:0] fr_store   [STORE_BYTES];
    bit                fr_written [STORE_BYTES];
    logic [ADDR_W-1:0] fr_starts  [QUEUE_DEPTH];
    int unsigned       fr_line_base = 0;
    int unsigned       fr_wr_pos    = 0;
    logic [BYTE_W-1:0] fr_last_byte = '0;
    bit                fr_resync    = 1'b0;
    int unsigned       fr_q_rd      = 0;
    int unsigned       fr_q_wr      = 0;

    t_result     replies_due [$];
    t_result     last_reply;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned cycles     = 0;
    bit          calm       = 1'b0;

    typedef struct {
        t_req               req;
        logic [BYTE_W-1:0]  data;
        logic [RADDR_W-1:0] addr;
        bit                 typed;
        t_result            reply;
    } t_script_row;

    // Directed rows; the reply column counts only where typed is set
    t_script_row script [SCRIPT_LEN] = '{
        '{REQ_POP,     8'h00,   12'd0,    1'b1, '{ST_EMPTY,   11'd0, 8'h00, 1'b0}},
        '{REQ_READ,    8'hFF,   12'd2048, 1'b1, '{ST_READ,    11'd0, 8'h00, 1'b0}},
        '{REQ_BYTE,    8'h00,   12'd0,    1'b1, '{ST_STORED,  11'd0, 8'h00, 1'b0}},
        '{REQ_BYTE,    8'hFF,   12'd2048, 1'b1, '{ST_STORED,  11'd0, 8'h00, 1'b0}},
        '{REQ_BYTE,    CHAR_CR, 12'd0,    1'b1, '{ST_STORED,  11'd0, 8'h00, 1'b0}},
        '{REQ_BYTE,    CHAR_LF, 12'd0,    1'b1, '{ST_QUEUED,  11'd0, 8'h00, 1'b1}},
        '{REQ_READ,    8'h5A,   12'd0,    1'b1, '{ST_READ,    11'd0, 8'h00, 1'b1}},
        '{REQ_READ,    8'h00,   12'd1,    1'b1, '{ST_READ,    11'd0, 8'hFF, 1'b1}},
        '{REQ_READ,    8'h00,   12'd2,    1'b1, '{ST_READ,    11'd0, 8'h0A, 1'b1}},
        '{REQ_READ,    8'h00,   12'd3,    1'b1, '{ST_READ,    11'd0, 8'h00, 1'b1}},
        '{REQ_POP,     8'hA5,   12'd2047, 1'b1, '{ST_POPPED,  11'd0, 8'h00, 1'b0}},
        '{REQ_POP,     8'h00,   12'd0,    1'b1, '{ST_EMPTY,   11'd0, 8'h00, 1'b0}},
        '{REQ_OVERRUN, 8'h00,   12'd0,    1'b1, '{ST_DISCARD, 11'd0, 8'h00, 1'b0}},
        '{REQ_BYTE,    8'h61,   12'd0,    1'b0, '0},
        '{REQ_BYTE,    CHAR_LF, 12'd0,    1'b0, '0},
        '{REQ_BYTE,    CHAR_CR, 12'd0,    1'b0, '0},
        '{REQ_BYTE,    CHAR_LF, 12'd0,    1'b1, '{ST_DISCARD, 11'd0, 8'h00, 1'b0}},
        '{REQ_BYTE,    CHAR_CR, 12'd0,    1'b0, '0},
        '{REQ_BYTE,    CHAR_CR, 12'd0,    1'b0, '0},
        '{REQ_BYTE,    CHAR_LF, 12'd0,    1'b1, '{ST_QUEUED,  11'd8, 8'h00, 1'b1}},
        '{REQ_BYTE,    CHAR_LF, 12'd0,    1'b0, '0},
        '{REQ_READ,    8'h00,   12'd11,   1'b0, '0},
        '{REQ_POP,     8'h00,   12'd0,    1'b1, '{ST_POPPED,  11'd8, 8'h00, 1'b0}}
    };

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void store_byte(input int unsigned at, input logic [BYTE_W-1:0] b);
        fr_store[at]   = b;
        fr_written[at] = 1'b1;
    endfunction

    // Advance the framer by one request and return its reply
    function automatic t_result framer_reply(input t_req req, input logic [BYTE_W-1:0] data,
                                             input logic [RADDR_W-1:0] addr);
        t_result     r;
        int unsigned span;
        r = '0;
        case (req)
            REQ_BYTE: begin
                if ((fr_wr_pos + 1) % STORE_BYTES == fr_line_base) begin
                    // no room left: drop and resync
                    fr_resync = 1'b1;
                    r.status  = ST_FULL;
                end else if (data == CHAR_LF && fr_last_byte == CHAR_CR) begin
                    // line end: LF over the CR slot, then a terminator
                    store_byte((fr_wr_pos + STORE_BYTES - 1) % STORE_BYTES, data);
                    store_byte(fr_wr_pos, '0);
                    if (fr_resync) begin
                        fr_resync = 1'b0;
                        r.status  = ST_DISCARD;
                    end else if ((fr_q_wr + 1) % QUEUE_DEPTH == fr_q_rd) begin
                        r.status = ST_QFULL;
                    end else begin
                        fr_starts[fr_q_wr] = ADDR_W'(fr_line_base);
                        fr_q_wr            = (fr_q_wr + 1) % QUEUE_DEPTH;
                        r.start_addr       = ADDR_W'(fr_line_base);
                        r.status           = ST_QUEUED;
                    end
                    fr_wr_pos    = (fr_wr_pos + 1) % STORE_BYTES;
                    fr_line_base = fr_wr_pos;
                end else begin
                    store_byte(fr_wr_pos, data);
                    fr_wr_pos = (fr_wr_pos + 1) % STORE_BYTES;
                    // ran off the end: move the partial line down to address 0
                    if (fr_wr_pos == 0) begin
                        span = STORE_BYTES - fr_line_base;
                        for (int i = 0; i < span; i++)
                            store_byte(i, fr_store[fr_line_base + i]);
                        fr_wr_pos    = span % STORE_BYTES;
                        fr_line_base = 0;
                    end
                    r.status = ST_STORED;
                end
                fr_last_byte = data;
            end
            REQ_OVERRUN: begin
                fr_resync = 1'b1;
                r.status  = ST_DISCARD;
            end
            REQ_POP: begin
                if (fr_q_rd != fr_q_wr) begin
                    r.start_addr = fr_starts[fr_q_rd];
                    fr_q_rd      = (fr_q_rd + 1) % QUEUE_DEPTH;
                    r.status     = ST_POPPED;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            default: begin
                if (addr < STORE_BYTES)
                    r.read_data = fr_store[addr];
                r.status = ST_READ;
            end
        endcase
        r.sentence_ready = (fr_q_rd != fr_q_wr);
        return r;
    endfunction

    // One transfer on the input stream; called and returning at a falling edge
    task automatic send_req(input t_req req, input logic [BYTE_W-1:0] data,
                            input logic [RADDR_W-1:0] addr, input bit typed,
                            input t_result typed_reply);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= IN_TDATA_W'({addr, data});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_reply = framer_reply(req, data, addr);
        replies_due.push_back(typed ? typed_reply : last_reply);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic feed(input logic [BYTE_W-1:0] b);
        send_req(REQ_BYTE, b, RADDR_W'($urandom_range(0, STORE_BYTES)), 1'b0, '0);
    endtask

    task automatic pop_req();
        send_req(REQ_POP, BYTE_W'($urandom_range(0, 255)),
                 RADDR_W'($urandom_range(0, STORE_BYTES)), 1'b0, '0);
    endtask

    task automatic read_req(input logic [RADDR_W-1:0] a);
        send_req(REQ_READ, BYTE_W'($urandom_range(0, 255)), a, 1'b0, '0);
    endtask

    task automatic overrun_req();
        send_req(REQ_OVERRUN, BYTE_W'($urandom_range(0, 255)),
                 RADDR_W'($urandom_range(0, STORE_BYTES)), 1'b0, '0);
    endtask

    // Random byte that never starts a line end
    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        return (b == CHAR_CR) ? 8'h2E : b;
    endfunction

    task automatic send_line(input int len);
        repeat (len) feed(body_byte());
        feed(CHAR_CR);
        feed(CHAR_LF);
    endtask

    // Read address near the write position, else anywhere written, else past the end
    function automatic logic [RADDR_W-1:0] pick_addr();
        int unsigned a;
        if ($urandom_range(0, 7) == 0)
            return RADDR_W'(STORE_BYTES);
        a = (fr_wr_pos + STORE_BYTES - 1 - $urandom_range(0, 63)) % STORE_BYTES;
        if (!fr_written[a])
            a = $urandom_range(0, STORE_BYTES - 1);
        return fr_written[a] ? RADDR_W'(a) : RADDR_W'(STORE_BYTES);
    endfunction

    // Hold the input stream until every reply is in
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (replies_due.size() != 0);
    endtask

    // Output stall pattern
    initial begin : drain_side
        forever begin
            @(negedge i_clk);
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each reply with the oldest expectation
    always @(posedge i_clk) begin : check_replies
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = t_status'(m_axis_tuser);
            got.start_addr     = m_axis_tdata[ADDR_W-1:0];
            got.read_data      = m_axis_tdata[ADDR_W +: BYTE_W];
            got.sentence_ready = m_axis_tdata[ADDR_W + BYTE_W];
            if (replies_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected reply: status %0d start %0d data 0x%02h ready %0b",
                             got.status, got.start_addr, got.read_data, got.sentence_ready);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.start_addr !== want.start_addr ||
                    got.read_data !== want.read_data ||
                    got.sentence_ready !== want.sentence_ready) begin
                    if (mismatches < 10)
                        $display({"reply mismatch: exp status %0d start %0d data 0x%02h ",
                                  "ready %0b, got status %0d start %0d data 0x%02h ready %0b"},
                                 want.status, want.start_addr, want.read_data,
                                 want.sentence_ready, got.status, got.start_addr,
                                 got.read_data, got.sentence_ready);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int pick;
        int goal;
        int room;
        int body;
        int target;
        int fulls;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (script[i])
            send_req(script[i].req, script[i].data, script[i].addr, script[i].typed,
                     script[i].reply);
        settle();

        // Random mix: mostly whole lines, with pops, reads, overruns and stray bytes
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_line(($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                       : $urandom_range(0, 12));
            else if (pick < 70)
                pop_req();
            else if (pick < 82)
                read_req(pick_addr());
            else if (pick < 87)
                overrun_req();
            else begin
                case ($urandom_range(0, 2))
                    0:       feed(CHAR_CR);
                    1:       feed(CHAR_LF);
                    default: feed(BYTE_W'($urandom_range(0, 255)));
                endcase
            end
        end
        settle();

        // Fill the sentence queue past its depth with no stalls on either side
        calm = 1'b1;
        repeat (QUEUE_DEPTH + 4) send_line($urandom_range(0, 3));
        calm = 1'b0;
        while (fr_q_rd != fr_q_wr) pop_req();
        pop_req();
        settle();

        // Lines sized to end on the last store slot, then a one-byte move
        feed(CHAR_CR);
        feed(CHAR_LF);
        while (fr_wr_pos != STORE_BYTES - 1) begin
            room = STORE_BYTES - 1 - fr_wr_pos;
            body = $urandom_range(5, 150);
            if (room < 2) begin
                feed(body_byte());
            end else begin
                if (room < body + 4)
                    body = room - 2;
                send_line(body);
                if ($urandom_range(0, 1) == 1)
                    pop_req();
                if ($urandom_range(0, 3) == 0)
                    read_req(pick_addr());
            end
        end
        feed(body_byte());
        feed(CHAR_CR);
        feed(CHAR_LF);
        read_req(RADDR_W'(0));
        settle();

        // A long line: large move, then the store fills and bytes are dropped
        target = $urandom_range(300, 1500);
        while (fr_wr_pos < target) begin
            send_line($urandom_range(5, 150));
            if ($urandom_range(0, 1) == 1)
                pop_req();
        end
        fulls = 0;
        while (fulls < 4) begin
            feed(body_byte());
            if (last_reply.status == ST_FULL)
                fulls++;
        end
        feed(CHAR_CR);
        feed(CHAR_LF);
        overrun_req();
        while (fr_q_rd != fr_q_wr) pop_req();
        pop_req();
        repeat (24) read_req(pick_addr());
        settle();

        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
